// ===== hdl/dq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the double-ended queue: item types and command and status codes.
// Has no dependencies; every other file of the block but dq_ring_mem uses it by scoped names.
package dq_pkg;

    // Command codes of an input item. Codes above CMD_STATUS act as status queries.
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_REAR   = 3'd3;
    localparam logic [2:0] CMD_STATUS     = 3'd4;

    // Status codes of a result item.
    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    // One input item.
    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] data_in;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data_out;
        logic [4:0]  old_count;
        logic [4:0]  new_count;
        logic [31:0] front_word;
        logic [31:0] rear_word;
        logic        is_empty;
        logic        is_full;
    } t_out_item;

endpackage

// ===== hdl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Double-ended queue of DEPTH words with a two-entry result queue at the output.
// Uses dq_pkg, dq_engine and dq_ring_mem.
//
// Usage:
//   Input channel: i_in_valid, i_in_item (command and word), o_in_stall.
//   Output channel: o_out_valid, o_out_item, i_out_stall. One result per item.
//   Push, status and failing commands, and pops that leave at most one entry,
//   finish at once: the result is visible the cycle after the item is taken.
//   A pop that leaves two or more entries also passes through the S_FILL state,
//   because the new front or rear word is read from the registered ring read port.
//   Sustained rate is one item per cycle while the receiver does not stall;
//   during such a pop o_in_stall is high and no new item is taken.
//   Reset (synchronous, active low) empties the queue and drops any results
//   still waiting; ring contents are not cleared, only overwritten by pushes.
//   When the receiver stalls, up to two results are held; once both slots are
//   taken, o_in_stall rises until a result leaves.
module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  dq_pkg::t_in_item  i_in_item,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output dq_pkg::t_out_item o_out_item,
    input  logic              i_out_stall
);

    localparam int AW = $clog2(DEPTH);

    logic                  eng_ready;
    logic                  accept;
    logic                  res_valid;
    dq_pkg::t_out_item     res;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    dq_pkg::t_out_item     r_q0, n_q0;
    dq_pkg::t_out_item     r_q1, n_q1;
    logic [1:0]            r_qcnt, n_qcnt;
    logic                  q_pop;
    logic                  room;

    dq_engine #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_ready     (eng_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    dq_ring_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ring_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Input handshake: take an item when the engine is free and its result has a slot.
    assign q_pop       = (r_qcnt != 2'd0) && !i_out_stall;
    assign room        = (r_qcnt != 2'd2) || q_pop;
    assign o_in_stall  = !(eng_ready && room);
    assign accept      = i_in_valid && eng_ready && room;
    assign o_out_valid = (r_qcnt != 2'd0);
    assign o_out_item  = r_q0;

    // Two-entry result queue.
    always_comb begin
        n_q0   = r_q0;
        n_q1   = r_q1;
        n_qcnt = r_qcnt;
        if (q_pop) begin
            n_q0   = r_q1;
            n_qcnt = n_qcnt - 2'd1;
        end
        if (res_valid) begin
            if (n_qcnt == 2'd0) begin
                n_q0 = res;
            end else begin
                n_q1 = res;
            end
            n_qcnt = n_qcnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= 2'd0;
        end else begin
            r_qcnt <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

`ifndef SYNTHESIS
    a_qcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt != 2'd3)
        else $error("result queue count out of range");

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (r_qcnt != 2'd2 || q_pop))
        else $error("result produced with no free slot");

    a_res_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> o_out_valid)
        else $error("result not presented after completion");
`endif

endmodule

// ===== hdl/dq_ring_mem.sv =====
`timescale 1ns / 1ps
// Ring storage of the double-ended queue: one write port and one read port
// with registered read data. Depends on nothing else.
module dq_ring_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int AW        = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/dq_engine.sv =====
`timescale 1ns / 1ps
// Command engine of the double-ended queue: head index, count, cached end words
// and the read-modify sequencing of the ring memory. Uses dq_pkg.
module dq_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  dq_pkg::t_in_item      i_item,
    output logic                  o_ready,
    output logic                  o_res_valid,
    output dq_pkg::t_out_item     o_res,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [DATA_WIDTH-1:0] o_wr_data,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr,
    input  logic [DATA_WIDTH-1:0] i_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FILL = 2'b10
    } t_eng_state;

    t_eng_state            r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [DATA_WIDTH-1:0] r_front, n_front;
    logic [DATA_WIDTH-1:0] r_rear, n_rear;
    logic [DATA_WIDTH-1:0] r_removed, n_removed;
    logic [CW-1:0]         r_old_count, n_old_count;
    logic                  r_fix_front, n_fix_front;

    logic [2:0]            cmd;
    logic [DATA_WIDTH-1:0] word;
    logic                  full;
    logic                  empty;
    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         head_inc;
    logic [AW:0]           sum_rear;
    logic [AW:0]           sum_prev;
    logic [AW-1:0]         wr_rear_pos;
    logic [AW-1:0]         rd_rear_pos;
    logic [1:0]            res_status;
    logic [DATA_WIDTH-1:0] res_removed;

    // Decoded command and ring positions around the held region.
    assign cmd      = i_item.command;
    assign word     = DATA_WIDTH'(i_item.data_in);
    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign sum_rear = {1'b0, r_head} + (AW + 1)'(r_count);
    assign sum_prev = sum_rear - (AW + 1)'(2);
    assign wr_rear_pos = (sum_rear >= (AW + 1)'(DEPTH)) ?
                         AW'(sum_rear - (AW + 1)'(DEPTH)) : AW'(sum_rear);
    assign rd_rear_pos = (sum_prev >= (AW + 1)'(DEPTH)) ?
                         AW'(sum_prev - (AW + 1)'(DEPTH)) : AW'(sum_prev);

    // Command sequencing. A pop that leaves two or more entries reads the new
    // end word from the ring and finishes in the following cycle, in S_FILL.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_front     = r_front;
        n_rear      = r_rear;
        n_removed   = r_removed;
        n_old_count = r_old_count;
        n_fix_front = r_fix_front;
        o_wr_en     = 1'b0;
        o_wr_addr   = wr_rear_pos;
        o_wr_data   = word;
        o_rd_en     = 1'b0;
        o_rd_addr   = head_inc;
        o_res_valid = 1'b0;
        res_status  = dq_pkg::STS_DONE;
        res_removed = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_old_count = r_count;
                    o_res_valid = 1'b1;
                    case (cmd)
                        dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_REAR: begin
                            if (full) begin
                                res_status = dq_pkg::STS_FULL;
                            end else begin
                                o_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                                if (cmd == dq_pkg::CMD_PUSH_FRONT) begin
                                    o_wr_addr = head_dec;
                                    n_head    = head_dec;
                                    n_front   = word;
                                    if (empty) begin
                                        n_rear = word;
                                    end
                                end else begin
                                    n_rear = word;
                                    if (empty) begin
                                        n_front = word;
                                    end
                                end
                            end
                        end
                        dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_REAR: begin
                            if (empty) begin
                                res_status = dq_pkg::STS_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                                if (cmd == dq_pkg::CMD_POP_FRONT) begin
                                    res_removed = r_front;
                                    n_head      = head_inc;
                                    if (r_count == CW'(2)) begin
                                        n_front = r_rear;
                                    end else if (r_count > CW'(2)) begin
                                        o_rd_en     = 1'b1;
                                        o_rd_addr   = head_inc;
                                        n_fix_front = 1'b1;
                                        n_removed   = r_front;
                                        n_state     = S_FILL;
                                        o_res_valid = 1'b0;
                                    end
                                end else begin
                                    res_removed = r_rear;
                                    if (r_count == CW'(2)) begin
                                        n_rear = r_front;
                                    end else if (r_count > CW'(2)) begin
                                        o_rd_en     = 1'b1;
                                        o_rd_addr   = rd_rear_pos;
                                        n_fix_front = 1'b0;
                                        n_removed   = r_rear;
                                        n_state     = S_FILL;
                                        o_res_valid = 1'b0;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                o_res_valid = 1'b1;
                res_removed = r_removed;
                n_state     = S_IDLE;
                if (r_fix_front) begin
                    n_front = i_rd_data;
                end else begin
                    n_rear = i_rd_data;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result item built from the state after the command.
    always_comb begin
        o_res.status     = res_status;
        o_res.data_out   = 32'(res_removed);
        o_res.old_count  = 5'(n_old_count);
        o_res.new_count  = 5'(n_count);
        o_res.front_word = (n_count != '0) ? 32'(n_front) : '0;
        o_res.rear_word  = (n_count != '0) ? 32'(n_rear) : '0;
        o_res.is_empty   = (n_count == '0);
        o_res.is_full    = (n_count == CW'(DEPTH));
    end

    assign o_ready = (r_state == S_IDLE);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Cached end words and the pending pop.
    always_ff @(posedge i_clk) begin
        r_front     <= n_front;
        r_rear      <= n_rear;
        r_removed   <= n_removed;
        r_old_count <= n_old_count;
        r_fix_front <= n_fix_front;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_fill_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL |=> r_state == S_IDLE)
        else $error("memory fill took more than one cycle");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> r_state == S_IDLE)
        else $error("item accepted while a pop is completing");

    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> !o_rd_en)
        else $error("ring read and write issued together");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue: random and directed commands are
// predicted by a ring model in a small scoreboard class. Depends on dq_pkg and double_ended_queue.
module tb;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int RANDOM_ITEMS = 1650;

    // Command codes the block treats as a plain status query.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // Bias of a random phase.
    typedef enum int {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIXED
    } t_phase;

    // Ring model of the queue and the replies it still owes.
    class deque_tracker;
        bit [31:0] ring[DEPTH];
        bit [3:0]  head;
        bit [4:0]  count;
        dq_pkg::t_out_item pending_replies[$];
        int        error_count;

        function new();
            head        = '0;
            count       = '0;
            error_count = 0;
        endfunction

        // Works out the reply to an accepted command and advances the ring.
        function void log_command(dq_pkg::t_in_item it);
            dq_pkg::t_out_item r;
            bit [3:0]  last_idx;
            r           = '0;
            r.status    = dq_pkg::STS_DONE;
            r.old_count = count;
            case (it.command)
                dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_REAR: begin
                    if (count == DEPTH) begin
                        r.status = dq_pkg::STS_FULL;
                    end else if (it.command == dq_pkg::CMD_PUSH_FRONT) begin
                        head       = head - 4'd1;
                        ring[head] = it.data_in;
                        count      = count + 5'd1;
                    end else begin
                        ring[head + count[3:0]] = it.data_in;
                        count                   = count + 5'd1;
                    end
                end
                dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_REAR: begin
                    if (count == 0) begin
                        r.status = dq_pkg::STS_EMPTY;
                    end else if (it.command == dq_pkg::CMD_POP_FRONT) begin
                        r.data_out = ring[head];
                        head       = head + 4'd1;
                        count      = count - 5'd1;
                    end else begin
                        last_idx   = head + count[3:0] - 4'd1;
                        r.data_out = ring[last_idx];
                        count      = count - 5'd1;
                    end
                end
                default: begin
                end
            endcase
            r.new_count = count;
            if (count != 0) begin
                last_idx     = head + count[3:0] - 4'd1;
                r.front_word = ring[head];
                r.rear_word  = ring[last_idx];
            end
            r.is_empty = (count == 0);
            r.is_full  = (count == DEPTH);
            pending_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (act_val !== exp_val) begin
                $error("field %s: expected %h, got %h", name, exp_val, act_val);
                error_count++;
            end
        endfunction

        // Compares one reply from the block with the oldest prediction.
        function void check_result(dq_pkg::t_out_item got);
            dq_pkg::t_out_item want;
            if (pending_replies.size() == 0) begin
                $error("reply with no command outstanding: %h", got);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                compare_field("status", 32'(want.status), 32'(got.status));
                compare_field("data_out", want.data_out, got.data_out);
                compare_field("old_count", 32'(want.old_count), 32'(got.old_count));
                compare_field("new_count", 32'(want.new_count), 32'(got.new_count));
                compare_field("front_word", want.front_word, got.front_word);
                compare_field("rear_word", want.rear_word, got.rear_word);
                compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    dq_pkg::t_in_item  in_item = '0;
    logic              in_stall;
    logic              out_valid;
    dq_pkg::t_out_item out_item;
    logic              out_stall = 1'b0;

    deque_tracker tracker = new();
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int sent_items = 0;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    always #1 i_clk = ~i_clk;

    // Receiver stalls in stretches: never, light, heavy or solid.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(1, 40);
            stall_mode = $urandom_range(0, 3);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= 1'b1;
        endcase
    end

    // Every reply taken by the receiver is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            tracker.check_result(out_item);
        end
    end

    // Offers one item, with a random gap at the end of each burst.
    task automatic send_cmd(logic [2:0] cmd, logic [31:0] word);
        dq_pkg::t_in_item it;
        int gap_len;
        it.command = cmd;
        it.data_in = word;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
            gap_len = $urandom_range(0, 6);
            if (gap_len != 0) begin
                in_valid <= 1'b0;
                repeat (gap_len) @(negedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        tracker.log_command(it);
        sent_items++;
    endtask

    // Holds the sender off until every reply has come back.
    task automatic wait_replies();
        @(negedge i_clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_replies.size() != 0) @(posedge i_clk);
    endtask

    // Picks a command with the bias of the current phase.
    function automatic logic [2:0] pick_cmd(t_phase phase);
        int roll;
        int push_pct;
        int pop_pct;
        roll = $urandom_range(0, 99);
        case (phase)
            PHASE_FILL: begin
                push_pct = 70;
                pop_pct  = 20;
            end
            PHASE_DRAIN: begin
                push_pct = 20;
                pop_pct  = 70;
            end
            default: begin
                push_pct = 45;
                pop_pct  = 45;
            end
        endcase
        if (roll < push_pct) begin
            return $urandom_range(0, 1) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_REAR;
        end else if (roll < push_pct + pop_pct) begin
            return $urandom_range(0, 1) ? dq_pkg::CMD_POP_FRONT : dq_pkg::CMD_POP_REAR;
        end else if ($urandom_range(0, 2) != 0) begin
            return dq_pkg::CMD_STATUS;
        end
        return 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    endfunction

    // Mostly random words, now and then all zeros or all ones.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_phase phase;
        int phase_len;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-queue errors, spare codes, extreme words, both ends.
        send_cmd(dq_pkg::CMD_STATUS, 32'h0000_0000);
        send_cmd(dq_pkg::CMD_POP_FRONT, 32'hFFFF_FFFF);
        send_cmd(dq_pkg::CMD_POP_REAR, 32'hFFFF_FFFF);
        send_cmd(CMD_SPARE_FIRST, 32'h1234_5678);
        send_cmd(CMD_SPARE_MID, 32'h0000_0000);
        send_cmd(CMD_SPARE_LAST, 32'hFFFF_FFFF);
        send_cmd(dq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_cmd(dq_pkg::CMD_PUSH_REAR, 32'h0000_0000);
        send_cmd(dq_pkg::CMD_PUSH_FRONT, 32'h5555_AAAA);
        send_cmd(CMD_SPARE_LAST, 32'h0000_0000);
        send_cmd(dq_pkg::CMD_STATUS, 32'hFFFF_FFFF);
        send_cmd(dq_pkg::CMD_POP_REAR, 32'h0000_0000);
        send_cmd(dq_pkg::CMD_POP_FRONT, 32'h0000_0000);
        send_cmd(dq_pkg::CMD_POP_FRONT, 32'h0000_0000);
        send_cmd(dq_pkg::CMD_POP_REAR, 32'h0000_0000);
        send_cmd(dq_pkg::CMD_PUSH_REAR, 32'hAAAA_5555);
        send_cmd(dq_pkg::CMD_POP_FRONT, 32'h0000_0000);
        wait_replies();

        // Random phases that fill to full, drain to empty or hover in between.
        while (sent_items < RANDOM_ITEMS) begin
            phase     = t_phase'($urandom_range(0, 2));
            phase_len = $urandom_range(40, 120);
            repeat (phase_len) send_cmd(pick_cmd(phase), pick_word());
            if ($urandom_range(0, 1) == 0) begin
                wait_replies();
            end
        end

        wait_replies();
        repeat (10) @(posedge i_clk);
        if (tracker.error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule
